// ----- hdl/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, symbol codes and ranking for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] SYM_CARET = 8'h5E;  // '^'
  localparam logic [7:0] SYM_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] SYM_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] SYM_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] SYM_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] SYM_OPEN  = 8'h28;  // '('
  localparam logic [7:0] SYM_CLOSE = 8'h29;  // ')'

  // Precedence offset by one so that unranked symbols sit at zero
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;
  localparam logic [1:0] RANK_POW  = 2'd3;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_marker;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       is_terminator;
    logic       overflowed;
    logic       last_of_run;
  } out_t;

  // Decision for the current step of the sequencer
  typedef struct packed {
    logic pop;
    logic is_operand;
    logic is_close;
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } state_t;

  function automatic logic [1:0] rank_of(input logic [7:0] s);
    logic [1:0] r;
    case (s)
      SYM_CARET:           r = RANK_POW;
      SYM_STAR, SYM_SLASH: r = RANK_MUL;
      SYM_PLUS, SYM_MINUS: r = RANK_ADD;
      default:             r = RANK_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/infix_to_postfix_converter.sv -----
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: one infix byte per transaction in, postfix bytes
// and a terminator out, with an operator stack held in registers.
//
//   channel  signals                      payload
//   input    in_valid / in_ready          in_item  (symbol, end_marker)
//   output   out_valid / out_ready        out_item (out_symbol, is_terminator,
//                                                   overflowed, last_of_run)
//
// One transaction at a time: the input is taken in ST_IDLE, then the
// sequencer steps once per stack pop and then finishes (operand emit, push
// or discard); an end marker also flushes the held byte before the
// terminator. The single stack read port and the one-deep hold register
// limit the sequencer to one pop per step. Output stalls freeze the
// sequencer.
// Synchronous reset clears the stack count and the overflow flag; no sweep.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  itp_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output itp_pkg::out_t out_item
);
  import itp_pkg::*;

  state_t           state, state_next;
  in_t              cur, cur_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic             overflow_seen, overflow_seen_next;
  logic             hold_valid, hold_valid_next;
  logic [7:0]       hold_sym, hold_sym_next;
  logic             out_valid_next;
  out_t             out_item_next;
  logic [7:0]       stack_mem [STACK_DEPTH];

  logic             slot_free;
  logic             empty;
  logic [IDX_W-1:0] top_idx;
  logic [7:0]       top;
  logic             push_en;
  logic             out_load;
  step_t            step;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign empty     = (stack_count == '0);
  assign top_idx   = IDX_W'(stack_count - CNT_W'(1));
  assign top       = stack_mem[top_idx];

  itp_step_decode u_decode (
    .cur   (cur),
    .top   (top),
    .empty (empty),
    .step  (step)
  );

  always_comb begin
    state_next         = state;
    cur_next           = cur;
    stack_count_next   = stack_count;
    overflow_seen_next = overflow_seen;
    hold_valid_next    = hold_valid;
    hold_sym_next      = hold_sym;
    out_item_next      = out_item;
    out_load           = 1'b0;
    push_en            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cur_next   = in_item;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (step.pop) begin
          // popped byte waits in hold until we know whether it is the last
          if (!hold_valid || slot_free) begin
            if (hold_valid) begin
              out_load      = 1'b1;
              out_item_next = '{hold_sym, 1'b0, 1'b0, 1'b0};
            end
            hold_sym_next    = top;
            hold_valid_next  = 1'b1;
            stack_count_next = stack_count - CNT_W'(1);
          end
        end else if (cur.end_marker) begin
          if (slot_free) begin
            out_load = 1'b1;
            if (hold_valid) begin
              out_item_next   = '{hold_sym, 1'b0, 1'b0, 1'b0};
              hold_valid_next = 1'b0;
            end else begin
              out_item_next      = '{8'h00, 1'b1, overflow_seen, 1'b1};
              overflow_seen_next = 1'b0;
              state_next         = ST_IDLE;
            end
          end
        end else if (step.is_operand) begin
          if (slot_free) begin
            out_load      = 1'b1;
            out_item_next = '{cur.symbol, 1'b0, 1'b0, 1'b1};
            state_next    = ST_IDLE;
          end
        end else if (!hold_valid || slot_free) begin
          if (hold_valid) begin
            out_load        = 1'b1;
            out_item_next   = '{hold_sym, 1'b0, 1'b0, 1'b1};
            hold_valid_next = 1'b0;
          end
          if (step.is_close) begin
            // drop the matching '(' if one is there
            if (!empty) begin
              stack_count_next = stack_count - CNT_W'(1);
            end
          end else if (stack_count == CNT_W'(STACK_DEPTH)) begin
            overflow_seen_next = 1'b1;
          end else begin
            push_en          = 1'b1;
            stack_count_next = stack_count + CNT_W'(1);
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = out_load ? 1'b1 : (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stack_count   <= '0;
      overflow_seen <= 1'b0;
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      stack_count   <= stack_count_next;
      overflow_seen <= overflow_seen_next;
      hold_valid    <= hold_valid_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    hold_sym <= hold_sym_next;
    out_item <= out_item_next;
    if (push_en) begin
      stack_mem[stack_count[IDX_W-1:0]] <= cur.symbol;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("held byte left behind at end of transaction");

  a_term_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.is_terminator) |-> (out_item.last_of_run &&
      out_item.out_symbol == 8'h00))
    else $error("terminator malformed");

  a_ovf_only_term: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.is_terminator) |-> !out_item.overflowed)
    else $error("overflow flag on ordinary byte");

  a_ovf_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_item_next.is_terminator) |=> !overflow_seen)
    else $error("overflow flag not cleared after terminator");
`endif

endmodule

// ----- hdl/itp_step_decode.sv -----
// ----------------------------------------------------------------------------
// itp_step_decode
// Classifies the current symbol and compares it with the stack top to decide
// whether the sequencer pops on this step.
// ----------------------------------------------------------------------------
module itp_step_decode (
  input  itp_pkg::in_t  cur,
  input  logic [7:0]    top,
  input  logic          empty,
  output itp_pkg::step_t step
);
  import itp_pkg::*;

  logic       operand;
  logic       close_sym;
  logic       open_sym;
  logic [1:0] r_in;
  logic [1:0] r_top;
  logic       left;
  logic       outranked;

  always_comb begin
    operand   = (cur.symbol inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
    close_sym = (cur.symbol == SYM_CLOSE);
    open_sym  = (cur.symbol == SYM_OPEN);
    r_in      = rank_of(cur.symbol);
    r_top     = rank_of(top);
    left      = (cur.symbol != SYM_CARET);
    outranked = (r_in < r_top) || ((r_in == r_top) && left);

    step.is_operand = !cur.end_marker && operand;
    step.is_close   = !cur.end_marker && close_sym;
    if (empty) begin
      step.pop = 1'b0;
    end else if (cur.end_marker) begin
      step.pop = 1'b1;
    end else if (operand || open_sym) begin
      step.pop = 1'b0;
    end else if (close_sym) begin
      step.pop = (top != SYM_OPEN);
    end else begin
      step.pop = outranked;
    end
  end

endmodule
